// File: rtl/frac_pkg.sv
package frac_pkg;

    localparam int DW          = 32;
    localparam int EXP_W       = 4;
    localparam int REQ_W       = 3;
    localparam int IN_WIDTH_DEF = 16;
    localparam int MAX_EXP_DEF  = 15;
    localparam int FIFO_DEPTH  = 2;
    localparam int OUT_FIELDS_W = 4 * DW + 1;
    localparam int M_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SUB    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MUL    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DIV    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POW    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REDUCE = 3'd5;

    typedef enum logic [2:0] {
        K_ADDEQ = 3'd0,
        K_CROSS = 3'd1,
        K_MUL   = 3'd2,
        K_DIV   = 3'd3,
        K_POW   = 3'd4,
        K_RED   = 3'd5,
        K_NONE  = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               sub;
        logic [EXP_W-1:0]   exp_cnt;
        logic signed [DW-1:0] na;
        logic signed [DW-1:0] da;
        logic signed [DW-1:0] nb;
        logic signed [DW-1:0] db;
    } job_t;

endpackage

// File: rtl/frac_front.sv
module frac_front #(
    parameter int IN_WIDTH = frac_pkg::IN_WIDTH_DEF,
    parameter int MAX_EXP  = frac_pkg::MAX_EXP_DEF,
    localparam int S_FIELDS_W = frac_pkg::REQ_W + 4 * IN_WIDTH + frac_pkg::EXP_W,
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output frac_pkg::job_t       q_job
);
    import frac_pkg::*;

    localparam int NA_LO  = REQ_W;
    localparam int DA_LO  = NA_LO + IN_WIDTH;
    localparam int NB_LO  = DA_LO + IN_WIDTH;
    localparam int DB_LO  = NB_LO + IN_WIDTH;
    localparam int EXP_LO = DB_LO + IN_WIDTH;

    job_t             fifo_reg [FIFO_DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    job_t             job_in;
    logic [REQ_W-1:0] req;
    logic [EXP_W-1:0] exp_raw;
    logic             push, pop;

    always_comb begin
        req          = s_tdata[REQ_W-1:0];
        exp_raw      = s_tdata[EXP_LO +: EXP_W];
        job_in.na    = DW'($signed(s_tdata[NA_LO +: IN_WIDTH]));
        job_in.da    = DW'($signed(s_tdata[DA_LO +: IN_WIDTH]));
        job_in.nb    = DW'($signed(s_tdata[NB_LO +: IN_WIDTH]));
        job_in.db    = DW'($signed(s_tdata[DB_LO +: IN_WIDTH]));
        job_in.sub   = (req == REQ_SUB);
        job_in.exp_cnt = (int'(exp_raw) > MAX_EXP) ? EXP_W'(MAX_EXP) : exp_raw;
        case (req)
            REQ_ADD, REQ_SUB: job_in.kind = (job_in.da == job_in.db) ? K_ADDEQ : K_CROSS;
            REQ_MUL:          job_in.kind = K_MUL;
            REQ_DIV:          job_in.kind = K_DIV;
            REQ_POW:          job_in.kind = K_POW;
            REQ_REDUCE:       job_in.kind = K_RED;
            default:          job_in.kind = K_NONE;
        endcase
    end

    assign s_tready = (count_reg != 2'(FIFO_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_job    = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= job_in;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(FIFO_DEPTH)) else $error("queue count out of range");
    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop on read");
    a_ptrs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'(FIFO_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers inconsistent when full");
`endif

endmodule

// File: rtl/frac_back.sv
module frac_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  frac_pkg::job_t                q_job,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [frac_pkg::M_DATA_W-1:0] m_tdata
);
    import frac_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_MULW = 8'b0000_0100,
        S_ADD  = 8'b0000_1000,
        S_PREP = 8'b0001_0000,
        S_GCD  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    job_t                  job_reg, job_next;
    logic                  step_reg, step_next;
    logic [EXP_W-1:0]      cnt_reg, cnt_next;
    logic signed [DW-1:0]  rn_reg, rn_next, rd_reg, rd_next, tmp_reg, tmp_next;
    logic                  ov_reg, ov_next;
    logic signed [2*DW-1:0] pn_reg, pn_next, pd_reg, pd_next;
    logic [DW-1:0]         u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [4:0]            k_reg, k_next, bit_reg, bit_next;
    logic [DW-1:0]         qn_reg, qn_next, qd_reg, qd_next;
    logic [DW-1:0]         remn_reg, remn_next, remd_reg, remd_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic signed [DW-1:0]  an, bn, ad, bd;
    logic                  pn_fit, pd_fit;
    logic signed [DW:0]    sum;
    logic [DW:0]           trn, trd;
    logic                  out_free;

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // operand selection for the two multipliers
    always_comb begin
        an = job_reg.na;
        bn = job_reg.db;
        ad = job_reg.da;
        bd = job_reg.nb;
        case (job_reg.kind)
            K_POW: begin
                an = rn_reg; bn = job_reg.na;
                ad = rd_reg; bd = job_reg.da;
            end
            K_MUL: begin
                bn = job_reg.nb;
                bd = job_reg.db;
            end
            K_CROSS: begin
                if (step_reg) begin
                    bd = job_reg.db;
                end else begin
                    ad = job_reg.nb; bd = job_reg.da;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        pn_fit = (pn_reg[2*DW-1:DW-1] == '0) || (pn_reg[2*DW-1:DW-1] == '1);
        pd_fit = (pd_reg[2*DW-1:DW-1] == '0) || (pd_reg[2*DW-1:DW-1] == '1);
        sum    = job_reg.sub ? ((DW+1)'(rn_reg) - (DW+1)'(tmp_reg))
                             : ((DW+1)'(rn_reg) + (DW+1)'(tmp_reg));
        trn    = {remn_reg, qn_reg[DW-1]};
        trd    = {remd_reg, qd_reg[DW-1]};
    end

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        rn_next      = rn_reg;
        rd_next      = rd_reg;
        tmp_next     = tmp_reg;
        ov_next      = ov_reg;
        pn_next      = pn_reg;
        pd_next      = pd_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        g_next       = g_reg;
        k_next       = k_reg;
        bit_next     = bit_reg;
        qn_next      = qn_reg;
        qd_next      = qd_reg;
        remn_next    = remn_reg;
        remd_next    = remd_reg;
        m_valid_next = (m_valid_reg && !m_tready);
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    job_next  = q_job;
                    step_next = 1'b0;
                    ov_next   = 1'b0;
                    cnt_next  = q_job.exp_cnt;
                    case (q_job.kind)
                        K_ADDEQ: begin
                            rn_next = q_job.na; tmp_next = q_job.nb; rd_next = q_job.da;
                            state_next = S_ADD;
                        end
                        K_CROSS, K_MUL, K_DIV: state_next = S_MUL;
                        K_POW: begin
                            rn_next = DW'(1); rd_next = DW'(1);
                            state_next = (q_job.exp_cnt == '0) ? S_PREP : S_MUL;
                        end
                        K_RED: begin
                            rn_next = q_job.na; rd_next = q_job.da;
                            state_next = S_PREP;
                        end
                        default: begin
                            rn_next = '0; rd_next = '0;
                            state_next = S_PREP;
                        end
                    endcase
                end
            end
            S_MUL: begin
                pn_next    = an * bn;
                pd_next    = ad * bd;
                state_next = S_MULW;
            end
            S_MULW: begin
                case (job_reg.kind)
                    K_CROSS: begin
                        if (step_reg) begin
                            rd_next    = pd_reg[DW-1:0];
                            ov_next    = ov_reg || !pd_fit;
                            state_next = S_ADD;
                        end else begin
                            rn_next    = pn_reg[DW-1:0];
                            tmp_next   = pd_reg[DW-1:0];
                            ov_next    = ov_reg || !pn_fit || !pd_fit;
                            step_next  = 1'b1;
                            state_next = S_MUL;
                        end
                    end
                    K_POW: begin
                        rn_next    = pn_reg[DW-1:0];
                        rd_next    = pd_reg[DW-1:0];
                        ov_next    = ov_reg || !pn_fit || !pd_fit;
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = (cnt_reg == EXP_W'(1)) ? S_PREP : S_MUL;
                    end
                    default: begin
                        rn_next    = pn_reg[DW-1:0];
                        rd_next    = pd_reg[DW-1:0];
                        ov_next    = ov_reg || !pn_fit || !pd_fit;
                        state_next = S_PREP;
                    end
                endcase
            end
            S_ADD: begin
                rn_next    = sum[DW-1:0];
                ov_next    = ov_reg || (sum[DW] != sum[DW-1]);
                state_next = S_PREP;
            end
            S_PREP: begin
                qn_next = rn_reg;
                qd_next = rd_reg;
                if (rn_reg > 0 && rd_reg > 0) begin
                    u_next     = rn_reg;
                    v_next     = rd_reg;
                    k_next     = '0;
                    state_next = S_GCD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_GCD: begin
                // binary gcd, one shift or subtract per cycle
                if (u_reg == v_reg) begin
                    g_next     = u_reg << k_reg;
                    remn_next  = '0;
                    remd_next  = '0;
                    bit_next   = '0;
                    state_next = S_DIV;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (u_reg > v_reg) begin
                    u_next = u_reg - v_reg;
                end else begin
                    v_next = v_reg - u_reg;
                end
            end
            S_DIV: begin
                // restoring division of both parts by the gcd, one bit a cycle
                if (trn >= {1'b0, g_reg}) begin
                    remn_next = DW'(trn - {1'b0, g_reg});
                    qn_next   = {qn_reg[DW-2:0], 1'b1};
                end else begin
                    remn_next = trn[DW-1:0];
                    qn_next   = {qn_reg[DW-2:0], 1'b0};
                end
                if (trd >= {1'b0, g_reg}) begin
                    remd_next = DW'(trd - {1'b0, g_reg});
                    qd_next   = {qd_reg[DW-2:0], 1'b1};
                end else begin
                    remd_next = trd[DW-1:0];
                    qd_next   = {qd_reg[DW-2:0], 1'b0};
                end
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 5'(DW - 1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({ov_reg, qd_reg, qn_reg, rd_reg, rn_reg});
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        step_reg   <= step_next;
        cnt_reg    <= cnt_next;
        rn_reg     <= rn_next;
        rd_reg     <= rd_next;
        tmp_reg    <= tmp_next;
        ov_reg     <= ov_next;
        pn_reg     <= pn_next;
        pd_reg     <= pd_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        g_reg      <= g_next;
        k_reg      <= k_next;
        bit_reg    <= bit_next;
        qn_reg     <= qn_next;
        qd_reg     <= qd_next;
        remn_reg   <= remn_next;
        remd_reg   <= remd_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GCD) |-> (u_reg != '0 && v_reg != '0))
        else $error("gcd operand reached zero");
    a_div_by_g: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (g_reg != '0))
        else $error("division by zero gcd");
    a_red_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free && rn_reg > 0 && rd_reg > 0)
        |-> (qn_reg != '0 && qd_reg != '0))
        else $error("reduced part became zero");
`endif

endmodule

// File: rtl/fraction_arith_reduce_top.sv
// steps: after accept, a request runs its multiply rounds (multiply, then writeback) and
// an add if it has them, then a sign check; when both raw parts are positive (always so
// for power 0) binary gcd steps and the division by the gcd follow before the output
// the back end takes one request at a time, held up by the gcd and divider loops
// a two-entry queue and the output register let input and output stall independently
// aresetn is synchronous, active low, and empties the queue and the output register
module fraction_arith_reduce_top #(
    parameter int IN_WIDTH = frac_pkg::IN_WIDTH_DEF,
    parameter int MAX_EXP  = frac_pkg::MAX_EXP_DEF,
    localparam int S_FIELDS_W = frac_pkg::REQ_W + 4 * IN_WIDTH + frac_pkg::EXP_W,
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // req_type, num_a, den_a, num_b, den_b, exponent
    input  logic [S_DATA_W-1:0]           s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // raw_num, raw_den, red_num, red_den, overflow
    output logic [frac_pkg::M_DATA_W-1:0] m_tdata
);
    import frac_pkg::*;

    logic q_valid, q_ready;
    job_t q_job;

    frac_front #(
        .IN_WIDTH (IN_WIDTH),
        .MAX_EXP  (MAX_EXP)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_job    (q_job)
    );

    frac_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_job    (q_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import frac_pkg::*;

    localparam int IW = IN_WIDTH_DEF;
    localparam int S_FIELDS_W = REQ_W + 4 * IW + EXP_W;
    localparam int S_DATA_W = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic                 ovf;
        logic signed [DW-1:0] red_den;
        logic signed [DW-1:0] red_num;
        logic signed [DW-1:0] raw_den;
        logic signed [DW-1:0] raw_num;
    } frac_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    frac_result_t pending_results[$];
    int  n_errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;
    int  op_count[8];

    fraction_arith_reduce_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // keep low 32 bits, flag anything outside the signed range
    function automatic longint wrap_to_word(input longint x, inout bit ovf);
        if (x < -64'sd2147483648 || x > 64'sd2147483647) ovf = 1'b1;
        return longint'(int'(x[31:0]));
    endfunction

    function automatic frac_result_t compute_fraction(input logic [2:0] op,
            input logic signed [IW-1:0] a_n, input logic signed [IW-1:0] a_d,
            input logic signed [IW-1:0] b_n, input logic signed [IW-1:0] b_d,
            input logic [EXP_W-1:0] pwr);
        frac_result_t r;
        longint na, da, nb, db, rn, rd, x, y;
        int unsigned g, t, u, v;
        int pw;
        bit ovf;
        ovf = 1'b0;
        r = '0;
        na = a_n; da = a_d; nb = b_n; db = b_d;
        rn = 0; rd = 0;
        pw = (pwr > MAX_EXP_DEF) ? MAX_EXP_DEF : pwr;
        case (op)
            REQ_ADD, REQ_SUB: begin
                if (da == db) begin
                    rd = da;
                    rn = wrap_to_word(op == REQ_ADD ? na + nb : na - nb, ovf);
                end else begin
                    x = wrap_to_word(na * db, ovf);
                    y = wrap_to_word(nb * da, ovf);
                    rd = wrap_to_word(da * db, ovf);
                    rn = wrap_to_word(op == REQ_ADD ? x + y : x - y, ovf);
                end
            end
            REQ_MUL: begin
                rn = wrap_to_word(na * nb, ovf);
                rd = wrap_to_word(da * db, ovf);
            end
            REQ_DIV: begin
                rn = wrap_to_word(na * db, ovf);
                rd = wrap_to_word(da * nb, ovf);
            end
            REQ_POW: begin
                rn = 1; rd = 1;
                for (int k = 0; k < pw; k++) begin
                    rn = wrap_to_word(rn * na, ovf);
                    rd = wrap_to_word(rd * da, ovf);
                end
            end
            REQ_REDUCE: begin
                rn = na; rd = da;
            end
            default: return r;
        endcase
        r.raw_num = rn[31:0];
        r.raw_den = rd[31:0];
        r.red_num = rn[31:0];
        r.red_den = rd[31:0];
        r.ovf = ovf;
        if (rn > 0 && rd > 0) begin
            u = rn; v = rd;
            while (v != 0) begin
                t = u % v; u = v; v = t;
            end
            g = u;
            if (g > 1) begin
                r.red_num = rn / g;
                r.red_den = rd / g;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic signed [IW-1:0] a_n,
            input logic signed [IW-1:0] a_d, input logic signed [IW-1:0] b_n,
            input logic signed [IW-1:0] b_d, input logic [EXP_W-1:0] pwr);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= S_DATA_W'({pwr, b_d, b_n, a_d, a_n, op});
        s_tvalid <= 1'b1;
        pending_results.push_back(compute_fraction(op, a_n, a_d, b_n, b_d, pwr));
        op_count[op]++;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [IW-1:0] rand_part();
        case ($urandom_range(5))
            0: return IW'($urandom_range(1, 12));
            1: return -IW'($urandom_range(1, 12));
            2: return IW'($urandom_range(1, 300));
            3: return {$urandom_range(1), $urandom_range(2)} == 0 ? '0 : IW'($urandom);
            default: return IW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [IW-1:0] mx, mn;
        mx = {1'b0, {(IW-1){1'b1}}};
        mn = {1'b1, {(IW-1){1'b0}}};
        send_request(REQ_ADD, 1, 4, 1, 4, 0);
        send_request(REQ_ADD, 1, 3, 1, 6, 0);
        send_request(REQ_SUB, 3, 8, 5, 8, 0);
        send_request(REQ_SUB, 1, 2, 1, 3, 0);
        send_request(REQ_ADD, mx, mx, mx, mx, 0);
        send_request(REQ_ADD, mn, mn, mn, mn, 0);
        send_request(REQ_SUB, mn, mx, mx, mn, 0);
        send_request(REQ_MUL, mn, mn, mn, mn, 0);
        send_request(REQ_MUL, 6, 8, 4, 9, 0);
        send_request(REQ_DIV, 2, 3, 4, 9, 0);
        send_request(REQ_DIV, 5, 7, 0, 3, 0);
        send_request(REQ_POW, 3, 5, 0, 0, 0);
        send_request(REQ_POW, 2, 3, 0, 0, 4'hf);
        send_request(REQ_POW, mn, mx, mx, mn, 4'hf);
        send_request(REQ_POW, -2, 3, 0, 0, 7);
        send_request(REQ_REDUCE, 12, 18, 0, 0, 0);
        send_request(REQ_REDUCE, -12, 18, 0, 0, 0);
        send_request(REQ_REDUCE, 12, 0, 0, 0, 0);
        send_request(REQ_REDUCE, 0, 5, 0, 0, 0);
        send_request(REQ_REDUCE, mx, 1, -1, -1, 4'hf);
        send_request(3'd6, mx, mx, mx, mx, 4'hf);
        send_request(3'd7, mn, mn, mn, mn, 4'hf);
    endtask

    task automatic test_random(input int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
            if (op <= REQ_SUB && $urandom_range(2) == 0) begin
                logic signed [IW-1:0] d;
                d = rand_part();
                send_request(op, rand_part(), d, rand_part(), d, EXP_W'($urandom));
            end else begin
                send_request(op, rand_part(), rand_part(), rand_part(), rand_part(),
                             EXP_W'($urandom));
            end
        end
    endtask

    // result side: random backpressure and in-order compare
    always @(posedge aclk) begin
        frac_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = frac_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, got);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (got.raw_num !== want.raw_num || got.raw_den !== want.raw_den ||
                        got.red_num !== want.red_num || got.red_den !== want.red_den ||
                        got.ovf !== want.ovf) begin
                        $display("%0t: mismatch expected raw %0d/%0d red %0d/%0d ovf %0b",
                                 $time, want.raw_num, want.raw_den, want.red_num,
                                 want.red_den, want.ovf);
                        $display("%0t:          actual   raw %0d/%0d red %0d/%0d ovf %0b",
                                 $time, got.raw_num, got.raw_den, got.red_num,
                                 got.red_den, got.ovf);
                        n_errors++;
                    end
                end
            end
            m_tready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        wait_drained();
        test_random(600);
        no_idle = 1'b1;
        test_random(200);
        no_idle = 1'b0;
        test_random(530);
        wait_drained();
        repeat (300) @(posedge aclk);
        $display("sent %0d requests, checked %0d results", n_sent, n_checked);
        $display("ops add %0d sub %0d mul %0d div %0d pow %0d reduce %0d unused %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
                 op_count[5], op_count[6] + op_count[7]);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/frac_pkg.sv
rtl/frac_front.sv
rtl/frac_back.sv
rtl/fraction_arith_reduce_top.sv
dv/testbench.sv
